>>> design/thermal_throttle_governor_unit_defines.svh
// Assertion macros shared by the thermal throttle governor RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef THERMAL_THROTTLE_GOVERNOR_UNIT_DEFINES_SVH
`define THERMAL_THROTTLE_GOVERNOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ttg_pkg.sv
// Package for the thermal throttle governor: item types, cap codes,
// register indexes and reset values. No dependencies.
`default_nettype none

package ttg_pkg;

  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HOT_THRESHOLD        = 3'd0,
    REG_COLD_THRESHOLD       = 3'd1,
    REG_HOT_DWELL_LIMIT      = 3'd2,
    REG_COLD_DWELL_LIMIT     = 3'd3,
    REG_BENCH_HOT_THRESHOLD  = 3'd4,
    REG_BENCH_COLD_THRESHOLD = 3'd5,
    REG_SENSOR_BYPASS        = 3'd6
  } reg_index_t;

  // Item kinds.
  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_PMU_EVENT = 1'b1;

  // CPU cap codes.
  localparam logic [1:0] CPU_CAP_DEFAULT   = 2'd0;
  localparam logic [1:0] CPU_CAP_LIMIT     = 2'd1;
  localparam logic [1:0] CPU_CAP_TIGHT     = 2'd2;
  localparam logic [1:0] CPU_CAP_BENCH_MAX = 2'd3;

  // GPU cap codes.
  localparam logic [1:0] GPU_CAP_DEFAULT   = 2'd0;
  localparam logic [1:0] GPU_CAP_LIMIT     = 2'd1;
  localparam logic [1:0] GPU_CAP_BENCH_MAX = 2'd2;

  localparam logic signed [8:0] ROOM_TEMP = 9'sd25;
  localparam logic [8:0]        CNT_MAX   = 9'd511;
  localparam logic [1:0]        ESC_MAX   = 2'd3;
  localparam logic [1:0]        ESC_TIGHTEN = 2'd2;

  // Register reset values.
  localparam logic signed [8:0] RST_HOT_THRESHOLD        = 9'sd58;
  localparam logic signed [8:0] RST_COLD_THRESHOLD       = 9'sd55;
  localparam logic [8:0]        RST_HOT_DWELL_LIMIT      = 9'd300;
  localparam logic [8:0]        RST_COLD_DWELL_LIMIT     = 9'd20;
  localparam logic signed [8:0] RST_BENCH_HOT_THRESHOLD  = 9'sd79;
  localparam logic signed [8:0] RST_BENCH_COLD_THRESHOLD = 9'sd70;

  typedef struct packed {
    logic              action;
    logic signed [8:0] temperature;
    logic              benchmark_mode;
  } sample_t;

  typedef struct packed {
    logic [1:0] cpu_cap;
    logic [1:0] gpu_cap;
    logic       cap_updated;
    logic       locked;
    logic       overheat_warning;
  } result_t;

  // Dwell counter increment that stops at the top.
  function automatic logic [8:0] sat_inc(input logic [8:0] c);
    return (c < CNT_MAX) ? c + 9'd1 : CNT_MAX;
  endfunction

endpackage

`default_nettype wire

>>> design/ttg_sample_if.sv
// Valid/ready channel that carries one temperature sample or PMU event item.
// Uses no package.
`default_nettype none

interface ttg_sample_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic signed [8:0] temperature;
  logic              benchmark_mode;

  modport source (output valid, output action, output temperature,
                  output benchmark_mode, input ready);
  modport sink   (input valid, input action, input temperature,
                  input benchmark_mode, output ready);
endinterface

`default_nettype wire

>>> design/ttg_result_if.sv
// Valid/ready channel that carries one governor result item.
// Uses no package.
`default_nettype none

interface ttg_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] cpu_cap;
  logic [1:0] gpu_cap;
  logic       cap_updated;
  logic       locked;
  logic       overheat_warning;

  modport source (output valid, output cpu_cap, output gpu_cap, output cap_updated,
                  output locked, output overheat_warning, input ready);
  modport sink   (input valid, input cpu_cap, input gpu_cap, input cap_updated,
                  input locked, input overheat_warning, output ready);
endinterface

`default_nettype wire

>>> design/thermal_throttle_governor_unit.sv
// Thermal throttle governor top level: input register, governor update, result register.
// Depends on ttg_pkg, ttg_sample_if, ttg_result_if and the defines header.
`default_nettype none
`include "thermal_throttle_governor_unit_defines.svh"

// The governor takes one item per clock cycle while the result side is not stalled and
// returns one result item for each, through the input register and then the result
// register. An accepted item waits in the input register; the dwell counters, escalation
// count, lock flag and cap levels are updated in the cycle the item moves into the result
// register, so each item's update sees the state left by the item before it. Configuration
// registers are written through cfg_wr_en, cfg_index and cfg_data and should only change
// while the block holds no item; an index beyond the last register is ignored.
module thermal_throttle_governor_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ttg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttg_pkg::CFG_DATA_W-1:0]  cfg_data,
  ttg_sample_if.sink                           samples,
  ttg_result_if.source                         results
);

  // Configuration registers.
  logic signed [8:0] hot_threshold;
  logic signed [8:0] cold_threshold;
  logic [8:0]        hot_dwell_limit;
  logic [8:0]        cold_dwell_limit;
  logic signed [8:0] bench_hot_threshold;
  logic signed [8:0] bench_cold_threshold;
  logic              sensor_bypass;

  // Governor state.
  logic [8:0] hot_count, hot_count_next;
  logic [8:0] cold_count, cold_count_next;
  logic [1:0] escalation_count, escalation_count_next;
  logic       lock_flag, lock_flag_next;
  logic [1:0] cpu_cap_level, cpu_cap_level_next;
  logic [1:0] gpu_cap_level, gpu_cap_level_next;

  // Pipeline registers.
  logic             s1_valid;
  ttg_pkg::sample_t s1_item;
  logic             res_valid;
  ttg_pkg::result_t res_item;
  ttg_pkg::result_t result_next;

  logic              advance;
  logic signed [8:0] eff_temp;
  logic              is_hot;
  logic              is_cold;
  logic              hot_done;
  logic              cold_done;
  logic [1:0]        esc_inc;
  logic              updated;
  logic              warning;

  // The input register moves on when the result register is free or being emptied.
  assign advance       = s1_valid && (!res_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold        <= ttg_pkg::RST_HOT_THRESHOLD;
      cold_threshold       <= ttg_pkg::RST_COLD_THRESHOLD;
      hot_dwell_limit      <= ttg_pkg::RST_HOT_DWELL_LIMIT;
      cold_dwell_limit     <= ttg_pkg::RST_COLD_DWELL_LIMIT;
      bench_hot_threshold  <= ttg_pkg::RST_BENCH_HOT_THRESHOLD;
      bench_cold_threshold <= ttg_pkg::RST_BENCH_COLD_THRESHOLD;
      sensor_bypass        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (ttg_pkg::reg_index_t'(cfg_index))
        ttg_pkg::REG_HOT_THRESHOLD:        hot_threshold        <= cfg_data;
        ttg_pkg::REG_COLD_THRESHOLD:       cold_threshold       <= cfg_data;
        ttg_pkg::REG_HOT_DWELL_LIMIT:      hot_dwell_limit      <= cfg_data;
        ttg_pkg::REG_COLD_DWELL_LIMIT:     cold_dwell_limit     <= cfg_data;
        ttg_pkg::REG_BENCH_HOT_THRESHOLD:  bench_hot_threshold  <= cfg_data;
        ttg_pkg::REG_BENCH_COLD_THRESHOLD: bench_cold_threshold <= cfg_data;
        ttg_pkg::REG_SENSOR_BYPASS:        sensor_bypass        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item.action         <= samples.action;
      s1_item.temperature    <= samples.temperature;
      s1_item.benchmark_mode <= samples.benchmark_mode;
    end
  end

  // Governor update for the item in the input register.
  always_comb begin
    hot_count_next        = hot_count;
    cold_count_next       = cold_count;
    escalation_count_next = escalation_count;
    lock_flag_next        = lock_flag;
    cpu_cap_level_next    = cpu_cap_level;
    gpu_cap_level_next    = gpu_cap_level;
    updated               = 1'b0;
    warning               = 1'b0;
    hot_done              = 1'b0;
    cold_done             = 1'b0;

    eff_temp = sensor_bypass ? ttg_pkg::ROOM_TEMP : s1_item.temperature;
    is_hot   = eff_temp > hot_threshold;
    is_cold  = eff_temp < cold_threshold;
    esc_inc  = (escalation_count < ttg_pkg::ESC_MAX) ? escalation_count + 2'd1
                                                      : escalation_count;

    if (s1_item.action == ttg_pkg::ACT_PMU_EVENT) begin
      cpu_cap_level_next = ttg_pkg::CPU_CAP_TIGHT;
      gpu_cap_level_next = ttg_pkg::GPU_CAP_LIMIT;
      hot_count_next     = '0;
      cold_count_next    = '0;
      lock_flag_next     = 1'b1;
      updated            = 1'b1;
    end else if (eff_temp > 9'sd0) begin
      if (s1_item.benchmark_mode) begin
        // Benchmark policy: caps follow the benchmark hot and cold thresholds, with a dead band between.
        priority if (eff_temp > bench_hot_threshold) begin
          cpu_cap_level_next = ttg_pkg::CPU_CAP_TIGHT;
          gpu_cap_level_next = ttg_pkg::GPU_CAP_LIMIT;
          updated            = 1'b1;
        end else if (eff_temp < bench_cold_threshold) begin
          cpu_cap_level_next = ttg_pkg::CPU_CAP_BENCH_MAX;
          gpu_cap_level_next = ttg_pkg::GPU_CAP_BENCH_MAX;
          updated            = 1'b1;
        end else begin
          // Inside the dead band the caps stay as they are.
        end
      end else begin
        // Dwell counting; a hot sample takes precedence over a cold one.
        priority if (is_hot) begin
          hot_count_next  = ttg_pkg::sat_inc(hot_count);
          cold_count_next = '0;
        end else if (is_cold) begin
          cold_count_next = ttg_pkg::sat_inc(cold_count);
          hot_count_next  = '0;
        end else begin
          hot_count_next  = '0;
          cold_count_next = '0;
        end

        hot_done  = is_hot && (hot_count_next >= hot_dwell_limit);
        cold_done = is_cold && (cold_count_next >= cold_dwell_limit);

        priority if (hot_done) begin
          escalation_count_next = esc_inc;
          if (esc_inc == ttg_pkg::ESC_MAX) begin
            warning = 1'b1;
          end else if (esc_inc == ttg_pkg::ESC_TIGHTEN) begin
            cpu_cap_level_next = ttg_pkg::CPU_CAP_TIGHT;
            updated            = 1'b1;
          end
          // Locking overrides the tightened CPU cap when not yet locked.
          if (!lock_flag) begin
            cpu_cap_level_next = ttg_pkg::CPU_CAP_LIMIT;
            gpu_cap_level_next = ttg_pkg::GPU_CAP_LIMIT;
            hot_count_next     = '0;
            cold_count_next    = '0;
            lock_flag_next     = 1'b1;
            updated            = 1'b1;
          end
        end else if (cold_done) begin
          escalation_count_next = '0;
          if (lock_flag) begin
            cpu_cap_level_next = ttg_pkg::CPU_CAP_DEFAULT;
            gpu_cap_level_next = ttg_pkg::GPU_CAP_DEFAULT;
            hot_count_next     = '0;
            cold_count_next    = '0;
            lock_flag_next     = 1'b0;
            updated            = 1'b1;
          end
        end else begin
          // No dwell completed: escalation, lock and caps hold.
        end

        // A counter that has reached its limit starts over.
        priority if (hot_count_next >= hot_dwell_limit) begin
          hot_count_next = '0;
        end else if (cold_count_next >= cold_dwell_limit) begin
          cold_count_next = '0;
        end else begin
          // Both counters are still short of their limits.
        end
      end
    end

    result_next.cpu_cap          = cpu_cap_level_next;
    result_next.gpu_cap          = gpu_cap_level_next;
    result_next.cap_updated      = updated;
    result_next.locked           = lock_flag_next;
    result_next.overheat_warning = warning;
  end

  // Governor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_count        <= '0;
      cold_count       <= '0;
      escalation_count <= '0;
      lock_flag        <= 1'b0;
      cpu_cap_level    <= ttg_pkg::CPU_CAP_DEFAULT;
      gpu_cap_level    <= ttg_pkg::GPU_CAP_DEFAULT;
    end else if (advance) begin
      hot_count        <= hot_count_next;
      cold_count       <= cold_count_next;
      escalation_count <= escalation_count_next;
      lock_flag        <= lock_flag_next;
      cpu_cap_level    <= cpu_cap_level_next;
      gpu_cap_level    <= gpu_cap_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= result_next;
    end
  end

  assign results.valid            = res_valid;
  assign results.cpu_cap          = res_item.cpu_cap;
  assign results.gpu_cap          = res_item.gpu_cap;
  assign results.cap_updated      = res_item.cap_updated;
  assign results.locked           = res_item.locked;
  assign results.overheat_warning = res_item.overheat_warning;

  // Checks on the governor logic.
  `TTG_ASSERT_SAME(a_ready_when_out_free, !res_valid, samples.ready, "input stalled with result register free")
  `TTG_ASSERT_NEXT(a_warning_at_max_esc, advance && result_next.overheat_warning, escalation_count == ttg_pkg::ESC_MAX, "warning without saturated escalation")
  `TTG_ASSERT_NEXT(a_caps_hold_no_update, advance && !result_next.cap_updated, cpu_cap_level == $past(cpu_cap_level) && gpu_cap_level == $past(gpu_cap_level), "caps changed without an update")
  `TTG_ASSERT_NEXT(a_pmu_forces_lock, advance && s1_item.action == ttg_pkg::ACT_PMU_EVENT, lock_flag && cpu_cap_level == ttg_pkg::CPU_CAP_TIGHT && gpu_cap_level == ttg_pkg::GPU_CAP_LIMIT, "PMU event did not force tight caps")
  `TTG_ASSERT_NEXT(a_state_holds_when_idle, !advance, $stable(escalation_count) && $stable(lock_flag), "state changed without an item")

endmodule

`default_nettype wire
